### src/e64v_pkg.sv
// Shared types and constants for the ELF64 image validator.
// Holds the request/result payload structs, status codes and queue entry layout.
// No dependencies.
package e64v_pkg;

	// Item kinds carried in req_type
	localparam logic REQ_HEADER = 1'b0;
	localparam logic REQ_ENTRY  = 1'b1;

	// Format constants for x86-64 user-space executables
	localparam logic [31:0] HEADER_BYTES    = 32'd64;
	localparam logic [15:0] MIN_ENTRY_BYTES = 16'd56;
	localparam logic [31:0] ELF_MAGIC       = 32'h464C_457F;
	localparam logic [7:0]  CLASS_64        = 8'd2;
	localparam logic [7:0]  DATA_LSB        = 8'd1;
	localparam logic [15:0] TYPE_EXEC       = 16'd2;
	localparam logic [15:0] MACHINE_X86_64  = 16'd62;
	localparam logic [31:0] VERSION_CURRENT = 32'd1;
	localparam logic [31:0] KIND_LOAD       = 32'd1;
	localparam logic [63:0] USER_ADDR_LIMIT = 64'h0000_8000_0000_0000;

	typedef enum logic [3:0] {
		ST_OK      = 4'd0,
		ST_TRUNC   = 4'd1,
		ST_MAGIC   = 4'd2,
		ST_CLASS   = 4'd3,
		ST_TYPE    = 4'd4,
		ST_MACHINE = 4'd5,
		ST_VERSION = 4'd6,
		ST_NOENTRY = 4'd7,
		ST_PHDR    = 4'd8,
		ST_OVERLAP = 4'd9,
		ST_SEQ     = 4'd10
	} status_t;

	typedef struct packed {
		logic        req_type;
		logic [47:0] ident_head;
		logic [63:0] type_machine_version;
		logic [63:0] entry_address;
		logic [63:0] table_offset;
		logic [15:0] table_count;
		logic [15:0] table_entry_size;
		logic [31:0] segment_kind;
		logic [63:0] segment_file_offset;
		logic [63:0] segment_file_bytes;
		logic [63:0] segment_mem_bytes;
		logic [63:0] segment_vaddr;
	} req_t;

	typedef struct packed {
		logic [3:0] status;
		logic       final_res;
	} rsp_t;

	// Classified item handed from the front end to the back end
	typedef struct packed {
		logic        req_type;
		status_t     pre_status;
		logic        is_load;
		logic [15:0] count;
		logic [63:0] vaddr;
		logic [63:0] mem_end;
	} q_entry_t;

endpackage

### src/e64v_front.sv
// Front end of the validator: accepts request transfers and classifies them.
// Runs every stateless header and segment check; depends on e64v_pkg.
module e64v_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [31:0]       image_size,
	input  logic              req_valid,
	output logic              req_ready,
	input  e64v_pkg::req_t    req,
	output logic              push_valid,
	input  logic              push_ready,
	output e64v_pkg::q_entry_t push_data
);

	// Input-side results (before the stage register)
	e64v_pkg::status_t early_d;
	logic [31:0] prod_d;
	logic [64:0] fend_d;
	logic [64:0] mend_d;

	// Stage 1 registers
	logic                v_s1;
	logic                req_type_s1;
	e64v_pkg::status_t   early_s1;
	logic [63:0]         offset_s1;
	logic [31:0]         prod_s1;
	logic                esz_small_s1;
	logic [64:0]         fend_s1;
	logic                msz_lt_fsz_s1;
	logic                va_high_s1;
	logic [64:0]         mend_s1;
	logic [63:0]         vaddr_s1;
	logic [15:0]         count_s1;
	logic                is_load_s1;

	logic [64:0] table_end;
	e64v_pkg::status_t pre_status;
	logic accept;

	assign req_ready = !v_s1 || push_ready;
	assign accept    = req_valid && req_ready;

	// Ordered header checks that need no arithmetic
	always_comb begin
		priority if (image_size < e64v_pkg::HEADER_BYTES) begin
			early_d = e64v_pkg::ST_TRUNC;
		end else if (req.ident_head[31:0] != e64v_pkg::ELF_MAGIC) begin
			early_d = e64v_pkg::ST_MAGIC;
		end else if (req.ident_head[39:32] != e64v_pkg::CLASS_64 ||
				req.ident_head[47:40] != e64v_pkg::DATA_LSB) begin
			early_d = e64v_pkg::ST_CLASS;
		end else if (req.type_machine_version[15:0] != e64v_pkg::TYPE_EXEC) begin
			early_d = e64v_pkg::ST_TYPE;
		end else if (req.type_machine_version[31:16] != e64v_pkg::MACHINE_X86_64) begin
			early_d = e64v_pkg::ST_MACHINE;
		end else if (req.type_machine_version[63:32] != e64v_pkg::VERSION_CURRENT) begin
			early_d = e64v_pkg::ST_VERSION;
		end else if (req.entry_address == 64'd0) begin
			early_d = e64v_pkg::ST_NOENTRY;
		end else if (req.table_offset == 64'd0 || req.table_count == 16'd0) begin
			early_d = e64v_pkg::ST_PHDR;
		end else begin
			early_d = e64v_pkg::ST_OK;
		end
	end

	// Table size product and segment end sums, carry kept
	assign prod_d = 32'(req.table_count) * 32'(req.table_entry_size);
	assign fend_d = {1'b0, req.segment_file_offset} + {1'b0, req.segment_file_bytes};
	assign mend_d = {1'b0, req.segment_vaddr} + {1'b0, req.segment_mem_bytes};

	// Hold stage valid until the queue takes the item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (req_ready) begin
			v_s1 <= req_valid;
		end
	end

	// Capture stage payload on each transfer
	always_ff @(posedge clk) begin
		if (accept) begin
			req_type_s1   <= req.req_type;
			early_s1      <= early_d;
			offset_s1     <= req.table_offset;
			prod_s1       <= prod_d;
			esz_small_s1  <= req.table_entry_size < e64v_pkg::MIN_ENTRY_BYTES;
			fend_s1       <= fend_d;
			msz_lt_fsz_s1 <= req.segment_mem_bytes < req.segment_file_bytes;
			va_high_s1    <= req.segment_vaddr >= e64v_pkg::USER_ADDR_LIMIT;
			mend_s1       <= mend_d;
			vaddr_s1      <= req.segment_vaddr;
			count_s1      <= req.table_count;
			is_load_s1    <= req.segment_kind == e64v_pkg::KIND_LOAD;
		end
	end

	assign table_end = {1'b0, offset_s1} + {33'd0, prod_s1};

	// Finish classification against the image size
	always_comb begin
		if (req_type_s1 == e64v_pkg::REQ_HEADER) begin
			priority if (early_s1 != e64v_pkg::ST_OK) begin
				pre_status = early_s1;
			end else if (table_end[64] || table_end[63:0] > {32'd0, image_size}) begin
				pre_status = e64v_pkg::ST_TRUNC;
			end else if (esz_small_s1) begin
				pre_status = e64v_pkg::ST_PHDR;
			end else begin
				pre_status = e64v_pkg::ST_OK;
			end
		end else begin
			priority if (fend_s1[64] || fend_s1[63:0] > {32'd0, image_size}) begin
				pre_status = e64v_pkg::ST_TRUNC;
			end else if (msz_lt_fsz_s1 || va_high_s1) begin
				pre_status = e64v_pkg::ST_PHDR;
			end else if (mend_s1[64] || mend_s1[63:0] > e64v_pkg::USER_ADDR_LIMIT) begin
				pre_status = e64v_pkg::ST_PHDR;
			end else begin
				pre_status = e64v_pkg::ST_OK;
			end
		end
	end

	assign push_valid           = v_s1;
	assign push_data.req_type   = req_type_s1;
	assign push_data.pre_status = pre_status;
	assign push_data.is_load    = is_load_s1;
	assign push_data.count      = count_s1;
	assign push_data.vaddr      = vaddr_s1;
	assign push_data.mem_end    = mend_s1[63:0];

endmodule

### src/e64v_queue.sv
// Short queue between the front and back ends of the validator.
// Register-based ring of classified items; depends on e64v_pkg.
module e64v_queue #(
	parameter int DEPTH = 2
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push_valid,
	output logic               push_ready,
	input  e64v_pkg::q_entry_t push_data,
	output logic               pop_valid,
	input  logic               pop_ready,
	output e64v_pkg::q_entry_t pop_data
);

	localparam int PtrW = $clog2(DEPTH);
	localparam int CntW = $clog2(DEPTH + 1);
	localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);

	e64v_pkg::q_entry_t slots_q [DEPTH];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;
	logic push;
	logic pop;

	assign push_ready = count_q != CntW'(DEPTH);
	assign pop_valid  = count_q != '0;
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_data   = slots_q[rd_ptr_q];

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Write the incoming item
	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

### src/e64v_back.sv
// Back end of the validator: applies sequencing state to classified items.
// Owns sticky status, entry count and segment order; depends on e64v_pkg.
module e64v_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               pop_valid,
	output logic               pop_ready,
	input  e64v_pkg::q_entry_t pop_data,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output e64v_pkg::rsp_t     rsp
);

	logic [63:0]       last_seg_end_q;
	logic [15:0]       remaining_q;
	e64v_pkg::status_t sticky_q;
	logic              accepted_q;
	logic              rsp_valid_q;
	e64v_pkg::rsp_t    rsp_q;

	logic [63:0]       last_seg_end_d;
	logic [15:0]       remaining_d;
	e64v_pkg::status_t sticky_d;
	logic              accepted_d;
	e64v_pkg::status_t st_d;
	logic              fin_d;
	logic [15:0]       rem_dec;
	logic              pop;

	assign pop_ready = !rsp_valid_q || rsp_ready;
	assign pop       = pop_valid && pop_ready;
	assign rem_dec   = remaining_q - 16'd1;

	// Sequence the item against the current image
	always_comb begin
		last_seg_end_d = last_seg_end_q;
		remaining_d    = remaining_q;
		sticky_d       = sticky_q;
		accepted_d     = accepted_q;
		st_d           = e64v_pkg::ST_OK;
		fin_d          = 1'b0;
		if (pop_data.req_type == e64v_pkg::REQ_HEADER) begin
			st_d           = pop_data.pre_status;
			last_seg_end_d = '0;
			if (pop_data.pre_status != e64v_pkg::ST_OK) begin
				sticky_d    = pop_data.pre_status;
				remaining_d = '0;
				accepted_d  = 1'b0;
				fin_d       = 1'b1;
			end else begin
				sticky_d    = e64v_pkg::ST_OK;
				remaining_d = pop_data.count;
				accepted_d  = 1'b1;
			end
		end else if (sticky_q != e64v_pkg::ST_OK) begin
			st_d  = sticky_q;
			fin_d = 1'b1;
		end else if (!accepted_q || remaining_q == '0) begin
			st_d  = e64v_pkg::ST_SEQ;
			fin_d = 1'b1;
		end else begin
			remaining_d = rem_dec;
			if (pop_data.is_load) begin
				priority if (pop_data.pre_status != e64v_pkg::ST_OK) begin
					st_d = pop_data.pre_status;
				end else if (pop_data.vaddr < last_seg_end_q) begin
					st_d = e64v_pkg::ST_OVERLAP;
				end else begin
					st_d           = e64v_pkg::ST_OK;
					last_seg_end_d = pop_data.mem_end;
				end
			end
			if (st_d != e64v_pkg::ST_OK) begin
				sticky_d    = st_d;
				remaining_d = '0;
				accepted_d  = 1'b0;
				fin_d       = 1'b1;
			end else if (rem_dec == '0) begin
				accepted_d = 1'b0;
				fin_d      = 1'b1;
			end
		end
	end

	// Update state and the result register on each pop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_seg_end_q <= '0;
			remaining_q    <= '0;
			sticky_q       <= e64v_pkg::ST_OK;
			accepted_q     <= 1'b0;
			rsp_valid_q    <= 1'b0;
		end else if (pop) begin
			last_seg_end_q <= last_seg_end_d;
			remaining_q    <= remaining_d;
			sticky_q       <= sticky_d;
			accepted_q     <= accepted_d;
			rsp_valid_q    <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// Load the result payload
	always_ff @(posedge clk) begin
		if (pop) begin
			rsp_q.status    <= st_d;
			rsp_q.final_res <= fin_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// A sticky error leaves no entries pending
	assert property (@(posedge clk) disable iff (!arst_n)
		sticky_q != e64v_pkg::ST_OK |-> !accepted_q && remaining_q == '0)
		else $error("sticky error with entries still pending");

	// An active header always has entries left
	assert property (@(posedge clk) disable iff (!arst_n)
		accepted_q == (remaining_q != '0))
		else $error("header flag and entry count disagree");

	// Every failing result ends the image
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_q.status != e64v_pkg::ST_OK |-> rsp_q.final_res)
		else $error("error result without final flag");

	// Segment ends stay at or below the user address limit
	assert property (@(posedge clk) disable iff (!arst_n)
		last_seg_end_q <= e64v_pkg::USER_ADDR_LIMIT)
		else $error("segment end above user address limit");

endmodule

### src/elf64_image_validator_top.sv
// ELF64 image validator, top level. One request transfer in, one result out.
// A request passes through the front stage register, the queue and the result register in turn.
// Throughput: one item per cycle while rsp_ready holds; front stage, queue and result register pipeline.
// Reset (arst_n low) clears image_size, sequencing state, queue and all valid flags.
// Instantiates e64v_front, e64v_queue and e64v_back; uses e64v_pkg.
module elf64_image_validator_top #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_we,
	input  logic [31:0]    cfg_data,
	input  logic           req_valid,
	output logic           req_ready,
	input  e64v_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output e64v_pkg::rsp_t rsp
);

	logic [31:0] image_size_q;

	logic               push_valid;
	logic               push_ready;
	e64v_pkg::q_entry_t push_data;
	logic               pop_valid;
	logic               pop_ready;
	e64v_pkg::q_entry_t pop_data;

	// Hold the configured image size
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_size_q <= '0;
		end else if (cfg_we) begin
			image_size_q <= cfg_data;
		end
	end

	e64v_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.image_size (image_size_q),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.req        (req),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	e64v_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	e64v_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule
